/* hdl/msd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg
// Widths, limits, codes and the job record shared by the mean / std-dev block.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int MAX_SAMPLES = 4096;

    localparam int SAMPLE_W  = 24;
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W     = 36;
    localparam int SQ_W      = 2 * SAMPLE_W - 1;
    localparam int SUMSQ_W   = 59;
    localparam int MEAN_W    = 32;
    localparam int STD_W     = 31;
    localparam int STATUS_W  = 2;
    localparam int FRAC_BITS = 8;

    // finish unit
    localparam int M_W       = 24;
    localparam int MUL_A_W   = 36;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 72;
    localparam int VAR_SHIFT = 16;
    localparam int DQ_W      = ACC_W + VAR_SHIFT;
    localparam int DIV_STEPS = DQ_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int MUL_STEPS = 4;
    localparam int MSTEP_W   = $clog2(MUL_STEPS + 1);
    localparam int ROOT_W    = 62;
    localparam int RES_W     = ROOT_W + 1;

    localparam logic [RES_W-1:0] ROOT_BIT0 = RES_W'(1) << (ROOT_W);
    localparam logic [STD_W-1:0] STD_SAT   = {STD_W{1'b1}};

    // job queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0]        n;
        logic signed [SUM_W-1:0] sum;
        logic [SUMSQ_W-1:0]      sumsq;
        logic                    ovf;
    } job_t;

endpackage

/* hdl/msd_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_in_if
// Sample channel: valid / ready with one signed sample and a last flag.
// ----------------------------------------------------------------------------
interface msd_in_if;
    import msd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

/* hdl/msd_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_out_if
// Result channel: valid / ready with mean, std-dev, sample count and status.
// ----------------------------------------------------------------------------
interface msd_out_if;
    import msd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [MEAN_W-1:0] mean;
    logic [STD_W-1:0]         std_dev;
    logic [CNT_W-1:0]         sample_total;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output mean, output std_dev, output sample_total,
                    output status, input ready);
    modport sink   (input valid, input mean, input std_dev, input sample_total,
                    input status, output ready);
endinterface

/* hdl/msd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_front
// Squares each sample, accumulates count / sum / sum of squares and hands a
// finished set to the job queue on the last sample.
// ----------------------------------------------------------------------------
module msd_front (
    input  logic          clk,
    input  logic          rst_n,
    msd_in_if.sink        samples,
    input  logic          q_full,
    output logic          push,
    output msd_pkg::job_t push_job
);
    import msd_pkg::*;

    logic                       s1_valid_reg;
    logic                       s1_last_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [SQ_W-1:0]            s1_sq_reg;

    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUMSQ_W-1:0]         sumsq_reg, sumsq_next;
    logic                       ovf_reg, ovf_next;

    logic                       accept;
    logic signed [2*SAMPLE_W-1:0] sq_full;

    // a last still in the square stage has not claimed its queue slot yet
    assign samples.ready = !q_full && !(s1_valid_reg && s1_last_reg);
    assign accept        = samples.valid && samples.ready;
    assign sq_full       = (2*SAMPLE_W)'(samples.sample) * (2*SAMPLE_W)'(samples.sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept && samples.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= samples.sample;
            s1_sq_reg     <= sq_full[SQ_W-1:0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        ovf_next   = ovf_reg;
        if (s1_valid_reg)
        begin
            if (count_reg < CNT_W'(MAX_SAMPLES))
            begin
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_reg + SUM_W'(s1_sample_reg);
                sumsq_next = sumsq_reg + SUMSQ_W'(s1_sq_reg);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    assign push           = s1_valid_reg && s1_last_reg;
    assign push_job.n     = count_next;
    assign push_job.sum   = sum_next;
    assign push_job.sumsq = sumsq_next;
    assign push_job.ovf   = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (push)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            ovf_reg   <= ovf_next;
        end
    end

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count past limit");

endmodule

/* hdl/msd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_queue
// Short job queue between the accumulating front and the finish unit.
// ----------------------------------------------------------------------------
module msd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  msd_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output msd_pkg::job_t head,
    output logic          empty
);
    import msd_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from empty queue");

endmodule

/* hdl/msd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_back
// Finish unit: n*sumsq - sum^2 by partial products, restoring divide shared
// by variance and mean, bitwise square root, then the result register.
// ----------------------------------------------------------------------------
module msd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  msd_pkg::job_t head,
    input  logic          empty,
    output logic          pop,
    msd_out_if.source     results
);
    import msd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_DIVS = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_DIVM = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [MSTEP_W-1:0] mstep_reg, mstep_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic               out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]   n_reg;
    logic [SUMSQ_W-1:0] sumsq_reg;
    logic [SUM_W-1:0]   mag_reg;
    logic               neg_reg;
    logic               ovf_reg;
    logic [M_W-1:0]     m_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]   accp_reg;
    logic [ACC_W-1:0]   accs_reg;
    logic [DQ_W-1:0]    dq_reg;
    logic [M_W-1:0]     rem_reg;
    logic [M_W-1:0]     div_reg;
    logic [ROOT_W-1:0]  x_reg;
    logic [RES_W-1:0]   res_reg;
    logic [RES_W-1:0]   bit_reg;
    logic               sat_reg;
    logic [STD_W-1:0]   std_reg;
    logic [MEAN_W-1:0]  mean_reg;

    logic [MEAN_W-1:0]  out_mean_reg;
    logic [STD_W-1:0]   out_std_reg;
    logic [CNT_W-1:0]   out_total_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic               load_out;
    logic               div_last;
    logic [SUM_W-1:0]   head_mag;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [1:0]         acc_idx;
    logic [ACC_W-1:0]   diff;
    logic [M_W:0]       trial;
    logic               div_ge;
    logic [M_W-1:0]     rem_nx;
    logic [DQ_W-1:0]    dq_nx;
    logic [RES_W:0]     root_trial;
    logic               root_take;
    logic [ROOT_W-1:0]  x_nx;
    logic [RES_W-1:0]   res_nx;
    logic [MEAN_W-1:0]  mean_mag;
    logic [MEAN_W-1:0]  mean_val;

    assign head_mag = head.sum[SUM_W-1] ? SUM_W'(-head.sum) : SUM_W'(head.sum);

    // partial products: n*sumsq in two pieces, then |sum|*|sum| in two pieces
    always_comb
    begin
        unique case (mstep_reg[1:0])
            2'd0:
            begin
                mul_a = sumsq_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(n_reg);
            end
            2'd1:
            begin
                mul_a = MUL_A_W'(sumsq_reg[SUMSQ_W-1:MUL_A_W]);
                mul_b = MUL_B_W'(n_reg);
            end
            2'd2:
            begin
                mul_a = mag_reg;
                mul_b = mag_reg[MUL_B_W-1:0];
            end
            default:
            begin
                mul_a = mag_reg;
                mul_b = mag_reg[SUM_W-1:MUL_B_W];
            end
        endcase
    end

    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign acc_idx = 2'(mstep_reg - MSTEP_W'(1));
    assign diff    = (accp_reg >= accs_reg) ? accp_reg - accs_reg : '0;

    // restoring divide, one quotient bit per cycle
    assign trial    = {rem_reg, dq_reg[DQ_W-1]};
    assign div_ge   = trial >= {1'b0, div_reg};
    assign rem_nx   = div_ge ? M_W'(trial - {1'b0, div_reg}) : trial[M_W-1:0];
    assign dq_nx    = {dq_reg[DQ_W-2:0], div_ge};
    assign div_last = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));

    // bitwise integer square root, two radicand bits per cycle
    assign root_trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign root_take  = {2'b0, x_reg} >= root_trial;
    assign x_nx       = root_take ? x_reg - root_trial[ROOT_W-1:0] : x_reg;
    assign res_nx     = root_take ? (res_reg >> 1) + bit_reg : res_reg >> 1;

    assign mean_mag = dq_nx[MEAN_W-1:0];
    assign mean_val = neg_reg ? MEAN_W'(-mean_mag) : mean_mag;

    assign pop      = (state_reg == S_IDLE) && !empty;
    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next     = state_reg;
        mstep_next     = mstep_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    state_next = S_MUL;
                    mstep_next = '0;
                end
            end
            S_MUL:
            begin
                mstep_next = mstep_reg + MSTEP_W'(1);
                if (mstep_reg == MSTEP_W'(MUL_STEPS))
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                state_next = S_DIVS;
                dcnt_next  = '0;
            end
            S_DIVS:
            begin
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (div_last)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = S_DIVM;
                    dcnt_next  = '0;
                end
            end
            S_DIVM:
            begin
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mstep_reg     <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mstep_reg     <= mstep_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    n_reg     <= head.n;
                    sumsq_reg <= head.sumsq;
                    mag_reg   <= head_mag;
                    neg_reg   <= head.sum[SUM_W-1];
                    ovf_reg   <= head.ovf;
                    accp_reg  <= '0;
                    accs_reg  <= '0;
                end
            end
            S_MUL:
            begin
                if (mstep_reg == '0)
                begin
                    m_reg <= M_W'(M_W'(n_reg) * M_W'(n_reg - CNT_W'(1)));
                end
                if (mstep_reg != MSTEP_W'(MUL_STEPS))
                begin
                    prod_reg <= prod;
                end
                if (mstep_reg != '0)
                begin
                    unique case (acc_idx)
                        2'd0:    accp_reg <= accp_reg + ACC_W'(prod_reg);
                        2'd1:    accp_reg <= accp_reg + (ACC_W'(prod_reg) << MUL_A_W);
                        2'd2:    accs_reg <= accs_reg + ACC_W'(prod_reg);
                        default: accs_reg <= accs_reg + (ACC_W'(prod_reg) << MUL_B_W);
                    endcase
                end
            end
            S_SUB:
            begin
                dq_reg  <= {diff, {VAR_SHIFT{1'b0}}};
                div_reg <= m_reg;
                rem_reg <= '0;
            end
            S_DIVS:
            begin
                dq_reg  <= dq_nx;
                rem_reg <= rem_nx;
                if (div_last)
                begin
                    // a quotient of 2^62 or more has a root past the std-dev range
                    sat_reg <= |dq_nx[DQ_W-1:ROOT_W];
                    x_reg   <= dq_nx[ROOT_W-1:0];
                    res_reg <= '0;
                    bit_reg <= ROOT_BIT0;
                end
            end
            S_ROOT:
            begin
                x_reg   <= x_nx;
                res_reg <= res_nx;
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    std_reg <= sat_reg ? STD_SAT : res_nx[STD_W-1:0];
                    dq_reg  <= DQ_W'({mag_reg, {FRAC_BITS{1'b0}}});
                    div_reg <= M_W'(n_reg);
                    rem_reg <= '0;
                end
            end
            S_DIVM:
            begin
                dq_reg  <= dq_nx;
                rem_reg <= rem_nx;
                if (div_last)
                begin
                    mean_reg <= mean_val;
                end
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    out_mean_reg  <= (n_reg == '0) ? '0 : mean_reg;
                    out_std_reg   <= (n_reg < CNT_W'(2)) ? '0 : std_reg;
                    out_total_reg <= n_reg;
                    priority if (ovf_reg)
                    begin
                        out_status_reg <= STATUS_DROP;
                    end
                    else if (n_reg < CNT_W'(2))
                    begin
                        out_status_reg <= STATUS_FEW;
                    end
                    else
                    begin
                        out_status_reg <= STATUS_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign results.valid        = out_valid_reg;
    assign results.mean         = out_mean_reg;
    assign results.std_dev      = out_std_reg;
    assign results.sample_total = out_total_reg;
    assign results.status       = out_status_reg;

    a_few_no_std: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_total_reg < CNT_W'(2))) |-> (out_std_reg == '0))
        else $error("std-dev reported for fewer than two samples");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (state_reg != S_MUL) || ($past(state_reg) == S_MUL))
        else $error("finish unit restarted mid job");

endmodule

/* hdl/mean_and_std_deviation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_and_std_deviation
// Running mean and sample standard deviation of sets of signed samples.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                     handshake
//  samples   in   sample[23:0] signed, last                   valid / ready
//  results   out  mean[31:0] signed, std_dev[30:0],           valid / ready
//                 sample_total[12:0], status[1:0]
//
//  samples are taken one per cycle while the queue has room; the cycle after a last sample is a bubble
//  the finish unit works through a 5-step multiply, two 88-step restoring
//  divides and a 32-step root for each set, so short sets queue up
//  a two-entry job queue lets the front keep accumulating while sets finish
//  samples stall when the queue is full and in the bubble after a last sample; results hold until taken
//  rst_n clears the front's counts and sums, the queue and all handshake state at once
// ----------------------------------------------------------------------------
module mean_and_std_deviation (
    input  logic      clk,
    input  logic      rst_n,
    msd_in_if.sink    samples,
    msd_out_if.source results
);
    import msd_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t head;

    msd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    msd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    msd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .results  (results)
    );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mean_and_std_deviation.
// A short table of hand-picked sets runs first: single samples, full-scale
// values, a saturating deviation and a few scattered sets. Random sets of
// mixed length and content follow. Every result is compared in all fields with
// the statistics hand-entered in its row or from an in-bench model of the
// running sums, under random idling on both channels but for the last third.
// ----------------------------------------------------------------------------
module tb;
    import msd_pkg::*;

    localparam int RAND_ITEMS = 1425;
    localparam int DRAIN_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [STD_W-1:0]         std_dev;
        logic [CNT_W-1:0]         sample_total;
        logic [STATUS_W-1:0]      status;
    } stats_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        int                         reps;
        bit                         last;
        bit                         scatter;
        bit                         typed;
        stats_t                     result;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    msd_in_if  samples_ch ();
    msd_out_if results_ch ();

    mean_and_std_deviation dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // model state of the running sums
    logic [CNT_W-1:0]        acc_count = '0;
    logic signed [SUM_W-1:0] acc_sum = '0;
    logic [SUMSQ_W-1:0]      acc_sumsq = '0;
    bit                      acc_drop = 1'b0;

    stats_t pending_stats[$];
    int     stats_errors = 0;
    int     results_seen = 0;
    int     samples_sent = 0;
    int     sets_sent = 0;
    int     drop_sets = 0;
    int     src_idle_pct = 25;
    int     snk_idle_pct = 78;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] rem, root, probe;
        rem = x;
        root = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // folds one sample into the sums; on a last sample forms the set statistics
    function automatic bit fold_sample(input logic signed [SAMPLE_W-1:0] value,
                                       input bit lst, output stats_t res);
        logic [127:0] n_w, mag, scaled_sq, sum_sq, spread, quot;
        logic [63:0]  var_q, root;
        longint       n;
        res = '0;
        if (acc_count < MAX_SAMPLES)
        begin
            acc_count = acc_count + 1'b1;
            acc_sum = acc_sum + value;
            acc_sumsq = acc_sumsq + SUMSQ_W'(longint'(value) * longint'(value));
        end
        else
            acc_drop = 1'b1;
        if (!lst)
            return 1'b0;
        n = longint'(acc_count);
        if (n > 0)
            res.mean = MEAN_W'((longint'(acc_sum) * 256) / n);
        if (n >= 2)
        begin
            n_w = 128'(acc_count);
            mag = (acc_sum < 0) ? 128'(-longint'(acc_sum)) : 128'(longint'(acc_sum));
            scaled_sq = n_w * 128'(acc_sumsq);
            sum_sq = mag * mag;
            spread = (scaled_sq > sum_sq) ? (scaled_sq - sum_sq) << 16 : '0;
            quot = spread / (n_w * (n_w - 1));
            var_q = (quot[127:64] != 0) ? '1 : quot[63:0];
            root = int_sqrt(var_q);
            res.std_dev = (root > 64'h7FFF_FFFF) ? STD_SAT : STD_W'(root);
        end
        res.sample_total = acc_count;
        if (acc_drop)
            res.status = STATUS_DROP;
        else if (n < 2)
            res.status = STATUS_FEW;
        else
            res.status = STATUS_OK;
        acc_count = '0;
        acc_sum = '0;
        acc_sumsq = '0;
        acc_drop = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int center);
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0:       return 24'h7FFFFF;
                    1:       return 24'h800000;
                    2:       return '0;
                    default: return -24'sd1;
                endcase
            end
            1, 2:    return SAMPLE_W'(int'($urandom_range(200)) - 100);
            3, 4, 5: return SAMPLE_W'($urandom());
            default: return SAMPLE_W'(center + int'($urandom_range(2000)) - 1000);
        endcase
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] value, input bit lst,
                               input bit typed, input stats_t typed_res);
        stats_t res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(negedge clk);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.sample <= value;
        samples_ch.last <= lst;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        samples_sent++;
        if (fold_sample(value, lst, res))
        begin
            sets_sent++;
            if (res.status == STATUS_DROP)
                drop_sets++;
            pending_stats.push_back(typed ? typed_res : res);
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
        results_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin : check_results
        stats_t got, want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            got = '{results_ch.mean, results_ch.std_dev, results_ch.sample_total,
                    results_ch.status};
            results_seen++;
            if (pending_stats.size() == 0)
            begin
                stats_errors++;
                if (stats_errors <= MAX_REPORTS)
                    $display("%0t: result with none expected: mean %0d std %0d n %0d st %0d",
                             $realtime, got.mean, got.std_dev, got.sample_total, got.status);
            end
            else
            begin
                want = pending_stats.pop_front();
                if (got !== want)
                begin
                    stats_errors++;
                    if (stats_errors <= MAX_REPORTS)
                        $display("%0t: mismatch exp mean %0d std %0d n %0d st %0d, %s%0d %0d %0d %0d",
                                 $realtime, want.mean, want.std_dev, want.sample_total,
                                 want.status, "got ", got.mean, got.std_dev,
                                 got.sample_total, got.status);
                end
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        stim_row_t                  plan [15];
        logic signed [SAMPLE_W-1:0] value;
        bit                         lst;
        int                         len, center, rand_items, pick;

        samples_ch.valid = 1'b0;
        samples_ch.sample = '0;
        samples_ch.last = 1'b0;

        plan = '{
            '{24'sd0,      1, 1'b1, 1'b0, 1'b1, '{32'sd0, 31'd0, 13'd1, STATUS_FEW}},
            '{24'h7FFFFF,  1, 1'b1, 1'b0, 1'b1, '{32'h7FFF_FF00, 31'd0, 13'd1, STATUS_FEW}},
            '{24'h800000,  1, 1'b1, 1'b0, 1'b1, '{32'h8000_0000, 31'd0, 13'd1, STATUS_FEW}},
            '{-24'sd1,     1, 1'b1, 1'b0, 1'b1, '{-32'sd256, 31'd0, 13'd1, STATUS_FEW}},
            // full-scale pair: deviation saturates
            '{24'h7FFFFF,  1, 1'b0, 1'b0, 1'b0, '0},
            '{24'h800000,  1, 1'b1, 1'b0, 1'b1, '{-32'sd128, STD_SAT, 13'd2, STATUS_OK}},
            '{24'sd5,      2, 1'b1, 1'b0, 1'b1, '{32'sd1280, 31'd0, 13'd2, STATUS_OK}},
            '{24'sd1,      1, 1'b0, 1'b0, 1'b0, '0},
            '{24'sd2,      1, 1'b1, 1'b0, 1'b0, '0},
            // negative mean truncates toward zero
            '{-24'sd1,     1, 1'b0, 1'b0, 1'b0, '0},
            '{24'sd0,      2, 1'b1, 1'b0, 1'b0, '0},
            '{24'sd100,    1, 1'b0, 1'b0, 1'b0, '0},
            '{-24'sd100,   1, 1'b1, 1'b0, 1'b0, '0},
            '{24'sd0,      3, 1'b1, 1'b1, 1'b0, '0},
            '{24'sd0,      5, 1'b1, 1'b1, 1'b0, '0}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[r])
        begin
            center = int'($urandom_range(16777215)) - 8388608;
            for (int k = 0; k < plan[r].reps; k++)
            begin
                lst = plan[r].last && (k == plan[r].reps - 1);
                value = plan[r].scatter ? pick_sample(center) : plan[r].value;
                push_sample(value, lst, plan[r].typed && lst, plan[r].result);
            end
        end

        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            if (rand_items >= 2 * RAND_ITEMS / 3)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else if (rand_items >= RAND_ITEMS / 3)
            begin
                src_idle_pct = 78;
                snk_idle_pct = 25;
            end
            pick = $urandom_range(99);
            if (pick < 60)
                len = $urandom_range(6, 1);
            else if (pick < 93)
                len = $urandom_range(32, 7);
            else if (pick < 99)
                len = $urandom_range(150, 33);
            else
                len = $urandom_range(500, 151);
            center = int'($urandom_range(16777215)) - 8388608;
            for (int k = 0; k < len; k++)
            begin
                push_sample(pick_sample(center), k == len - 1, 1'b0, '0);
                rand_items++;
            end
        end
        samples_ch.valid <= 1'b0;

        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d samples in %0d sets sent (%0d sets past the count limit)",
                 samples_sent, sets_sent, drop_sets);
        $display("%0d results checked, %0d mismatches", results_seen, stats_errors);
        if (stats_errors == 0 && pending_stats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
